// ===== src/qext_pkg.sv =====
package qext_pkg;

  localparam logic [30:0] P = 31'd2013265921;
  localparam logic [30:0] EXP = P - 31'd2;
  localparam logic [30:0] ONE = 31'd1;

  // Barrett constant for products below 2^62.
  localparam logic [63:0] MU_WIDE = (64'd1 << 62) / {33'd0, P};
  localparam logic [31:0] MU = MU_WIDE[31:0];

  localparam int MUL_LAT = 4;
  localparam int LANE_LAT = MUL_LAT + 4;
  localparam int POW_STEPS = 31;
  localparam int POW_LAT = POW_STEPS * MUL_LAT;
  localparam int INV_LAT = 3 * MUL_LAT + 2 + POW_LAT;
  localparam int TOT_LAT = LANE_LAT + INV_LAT;

  typedef logic [30:0] fe_t;
  typedef fe_t [3:0] ext_t;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_INV   = 3'd3,
    CMD_EMBED = 3'd4
  } cmd_t;

  function automatic fe_t canon(input logic [30:0] x);
    return (x >= P) ? x - P : x;
  endfunction

  function automatic fe_t fadd(input fe_t x, input fe_t y);
    logic [31:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, P}) begin
      s = s - {1'b0, P};
    end
    return s[30:0];
  endfunction

  function automatic fe_t fsub(input fe_t x, input fe_t y);
    logic [31:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, P} - {1'b0, y};
    end
    return s[30:0];
  endfunction

  function automatic fe_t fneg(input fe_t x);
    return fsub(31'd0, x);
  endfunction

  // Multiply by eleven, then bring the value below p with four trial subtractions.
  function automatic fe_t mul11(input fe_t x);
    logic [34:0] v;
    logic [34:0] p35;
    v = {4'd0, x} * 35'd11;
    p35 = {4'd0, P};
    if (v >= (p35 << 3)) v = v - (p35 << 3);
    if (v >= (p35 << 2)) v = v - (p35 << 2);
    if (v >= (p35 << 1)) v = v - (p35 << 1);
    if (v >= p35) v = v - p35;
    return v[30:0];
  endfunction

  // Reduces a sum that is below 4p.
  function automatic fe_t red4(input logic [32:0] s);
    logic [32:0] v;
    logic [32:0] p33;
    v = s;
    p33 = {2'd0, P};
    if (v >= (p33 << 1)) v = v - (p33 << 1);
    if (v >= p33) v = v - p33;
    return v[30:0];
  endfunction

endpackage

// ===== src/quartic_extension_field_alu.sv =====
// Channel  Handshake            Payload
// input    in_valid, in_stall   command, a_c0..a_c3, b_c0..b_c3
// output   out_valid, out_stall r_c0..r_c3, zero_inverse
//
// One item is taken every cycle while in_stall is low.
// The latency is set by the 31-step square-and-multiply chain for the base inverse.
// Reset clears the valid bits of the pipeline and the output stages.
// Results sit in an output register with one skid entry behind it; the whole
// pipeline freezes, and in_stall rises, only while the skid entry is full.
module quartic_extension_field_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [30:0] a_c0,
  input  logic [30:0] a_c1,
  input  logic [30:0] a_c2,
  input  logic [30:0] a_c3,
  input  logic [30:0] b_c0,
  input  logic [30:0] b_c1,
  input  logic [30:0] b_c2,
  input  logic [30:0] b_c3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] r_c0,
  output logic [30:0] r_c1,
  output logic [30:0] r_c2,
  output logic [30:0] r_c3,
  output logic        zero_inverse
);

  logic en;
  logic v0;
  logic [2:0] cmd0;
  qext_pkg::ext_t ea0;
  qext_pkg::ext_t eb0;
  qext_pkg::ext_t bsel;
  qext_pkg::ext_t ox [4];
  qext_pkg::ext_t oy [4];
  qext_pkg::ext_t simple;
  logic [3:0] wmask [4];

  logic v1;
  logic [2:0] cmd1;
  qext_pkg::ext_t a1;
  qext_pkg::ext_t simple1;
  qext_pkg::ext_t lx [4];
  qext_pkg::ext_t ly [4];
  qext_pkg::ext_t lane_z;

  logic dv [qext_pkg::TOT_LAT];
  logic [2:0] dcmd [qext_pkg::TOT_LAT];
  qext_pkg::ext_t dsimple [qext_pkg::TOT_LAT];
  qext_pkg::ext_t dlane [qext_pkg::INV_LAT];
  qext_pkg::ext_t da [qext_pkg::LANE_LAT];

  qext_pkg::ext_t inv_r;
  logic inv_zero;
  qext_pkg::ext_t res;
  logic res_flag;
  logic incoming;

  qext_pkg::ext_t ro;
  logic ro_flag;
  logic skid_valid;
  qext_pkg::ext_t rs;
  logic rs_flag;

  assign en = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0 <= command;
      ea0  <= {qext_pkg::canon(a_c3), qext_pkg::canon(a_c2),
               qext_pkg::canon(a_c1), qext_pkg::canon(a_c0)};
      eb0  <= {qext_pkg::canon(b_c3), qext_pkg::canon(b_c2),
               qext_pkg::canon(b_c1), qext_pkg::canon(b_c0)};
    end
  end

  // For the inverse the lanes form a * conj(a), whose x^0 and x^2 terms are n0 and n2.
  always_comb begin
    logic [1:0] j;
    j = '0;
    if (cmd0 == qext_pkg::CMD_INV) begin
      bsel = {qext_pkg::fneg(ea0[3]), ea0[2], qext_pkg::fneg(ea0[1]), ea0[0]};
    end else begin
      bsel = eb0;
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        j = 2'(k - i);
        ox[k][i] = ea0[i];
        oy[k][i] = bsel[j];
        wmask[k][i] = (i > k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (cmd0)
        qext_pkg::CMD_ADD:   simple[i] = qext_pkg::fadd(ea0[i], eb0[i]);
        qext_pkg::CMD_SUB:   simple[i] = qext_pkg::fsub(ea0[i], eb0[i]);
        qext_pkg::CMD_EMBED: simple[i] = (i == 0) ? ea0[0] : '0;
        default:             simple[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1    <= cmd0;
      a1      <= ea0;
      simple1 <= simple;
      for (int k = 0; k < 4; k++) begin
        lx[k] <= ox[k];
        ly[k] <= oy[k];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    qext_lane u_lane (
      .clk (clk),
      .en  (en),
      .x   (lx[k]),
      .y   (ly[k]),
      .wrap(wmask[k]),
      .z   (lane_z[k])
    );
  end

  qext_inv u_inv (
    .clk (clk),
    .en  (en),
    .n0  (lane_z[0]),
    .n2  (lane_z[2]),
    .a   (da[qext_pkg::LANE_LAT-1]),
    .r   (inv_r),
    .zero(inv_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qext_pkg::TOT_LAT; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v1;
      for (int i = 1; i < qext_pkg::TOT_LAT; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcmd[0]    <= cmd1;
      dsimple[0] <= simple1;
      for (int i = 1; i < qext_pkg::TOT_LAT; i++) begin
        dcmd[i]    <= dcmd[i-1];
        dsimple[i] <= dsimple[i-1];
      end
      dlane[0] <= lane_z;
      for (int i = 1; i < qext_pkg::INV_LAT; i++) begin
        dlane[i] <= dlane[i-1];
      end
      da[0] <= a1;
      for (int i = 1; i < qext_pkg::LANE_LAT; i++) begin
        da[i] <= da[i-1];
      end
    end
  end

  // Merge: pick the lane products, the inverse or the simple result by command.
  always_comb begin
    res_flag = 1'b0;
    case (dcmd[qext_pkg::TOT_LAT-1])
      qext_pkg::CMD_MUL: res = dlane[qext_pkg::INV_LAT-1];
      qext_pkg::CMD_INV: begin
        res = inv_zero ? '0 : inv_r;
        res_flag = inv_zero;
      end
      qext_pkg::CMD_ADD, qext_pkg::CMD_SUB, qext_pkg::CMD_EMBED:
        res = dsimple[qext_pkg::TOT_LAT-1];
      default: res = '0;
    endcase
  end

  assign incoming = en && dv[qext_pkg::TOT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        ro      <= rs;
        ro_flag <= rs_flag;
      end else begin
        ro      <= res;
        ro_flag <= res_flag;
      end
    end else if (incoming) begin
      rs      <= res;
      rs_flag <= res_flag;
    end
  end

  assign r_c0 = ro[0];
  assign r_c1 = ro[1];
  assign r_c2 = ro[2];
  assign r_c3 = ro[3];
  assign zero_inverse = ro_flag;

endmodule

// ===== src/qext_mulmod.sv =====
module qext_mulmod (
  input  logic             clk,
  input  logic             en,
  input  qext_pkg::fe_t    x,
  input  qext_pkg::fe_t    y,
  output qext_pkg::fe_t    z
);

  localparam logic [33:0] P34 = {3'd0, qext_pkg::P};
  localparam logic [33:0] P34X2 = P34 << 1;

  logic [61:0] prod;
  logic [61:0] prod2;
  logic [31:0] q;
  logic [33:0] rem;
  logic [63:0] qprod;
  logic [33:0] q34;
  logic [33:0] qp;
  logic [33:0] rem_next;
  logic [33:0] fix;

  assign qprod = {32'd0, prod[61:30]} * {32'd0, qext_pkg::MU};
  assign q34 = {2'd0, q};
  // p = 2^31 - 2^27 + 1, so q*p is two shifts, a subtraction and an add.
  assign qp = (q34 << 31) - (q34 << 27) + q34;
  assign rem_next = prod2[33:0] - qp;

  always_comb begin
    if (rem >= P34X2) begin
      fix = rem - P34X2;
    end else if (rem >= P34) begin
      fix = rem - P34;
    end else begin
      fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= {31'd0, x} * {31'd0, y};
      prod2 <= prod;
      q     <= qprod[63:32];
      rem   <= rem_next;
      z     <= fix[30:0];
    end
  end

endmodule

// ===== src/qext_lane.sv =====
module qext_lane (
  input  logic            clk,
  input  logic            en,
  input  qext_pkg::ext_t  x,
  input  qext_pkg::ext_t  y,
  input  logic [3:0]      wrap,
  output qext_pkg::fe_t   z
);

  qext_pkg::fe_t m [4];
  logic [32:0] lo_sum;
  logic [32:0] hi_sum;
  logic [32:0] lo_s;
  logic [32:0] hi_s;
  qext_pkg::fe_t lo_r;
  qext_pkg::fe_t hi_r;
  qext_pkg::fe_t lo_3;
  qext_pkg::fe_t t3;

  for (genvar i = 0; i < 4; i++) begin : g_mul
    qext_mulmod u_mul (
      .clk(clk),
      .en (en),
      .x  (x[i]),
      .y  (y[i]),
      .z  (m[i])
    );
  end

  // Terms that pass x^4 are collected apart and scaled by -11.
  always_comb begin
    lo_sum = '0;
    hi_sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (wrap[i]) begin
        hi_sum = hi_sum + {2'd0, m[i]};
      end else begin
        lo_sum = lo_sum + {2'd0, m[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_s <= lo_sum;
      hi_s <= hi_sum;
      lo_r <= qext_pkg::red4(lo_s);
      hi_r <= qext_pkg::red4(hi_s);
      lo_3 <= lo_r;
      t3   <= qext_pkg::mul11(hi_r);
      z    <= qext_pkg::fsub(lo_3, t3);
    end
  end

endmodule

// ===== src/qext_inv.sv =====
module qext_inv (
  input  logic            clk,
  input  logic            en,
  input  qext_pkg::fe_t   n0,
  input  qext_pkg::fe_t   n2,
  input  qext_pkg::ext_t  a,
  output qext_pkg::ext_t  r,
  output logic            zero
);

  typedef struct packed {
    qext_pkg::fe_t  n0;
    qext_pkg::fe_t  n2;
    qext_pkg::ext_t a;
  } side_t;

  localparam int ZLEN = qext_pkg::POW_LAT + 2 * qext_pkg::MUL_LAT;

  qext_pkg::fe_t sq0;
  qext_pkg::fe_t sq2;
  side_t s1 [qext_pkg::MUL_LAT];
  side_t sc;
  qext_pkg::fe_t c;
  side_t s2 [qext_pkg::POW_LAT];
  logic zl [ZLEN];
  qext_pkg::ext_t a3 [qext_pkg::MUL_LAT];
  qext_pkg::fe_t base [qext_pkg::POW_STEPS];
  qext_pkg::fe_t acc [qext_pkg::POW_STEPS + 1];
  qext_pkg::fe_t m0;
  qext_pkg::fe_t m2;
  qext_pkg::ext_t aa;
  qext_pkg::fe_t p_a0m0, p_a2m2, p_a1m0, p_a3m2;
  qext_pkg::fe_t p_a2m0, p_a0m2, p_a1m2, p_a3m0;

  // Norm down to the prime field: c = n0^2 + 11 n2^2.
  qext_mulmod u_sq0 (.clk(clk), .en(en), .x(n0), .y(n0), .z(sq0));
  qext_mulmod u_sq2 (.clk(clk), .en(en), .x(n2), .y(n2), .z(sq2));

  always_ff @(posedge clk) begin
    if (en) begin
      s1[0] <= '{n0: n0, n2: n2, a: a};
      for (int i = 1; i < qext_pkg::MUL_LAT; i++) begin
        s1[i] <= s1[i-1];
      end
      c  <= qext_pkg::fadd(sq0, qext_pkg::mul11(sq2));
      sc <= s1[qext_pkg::MUL_LAT-1];
      s2[0] <= sc;
      for (int i = 1; i < qext_pkg::POW_LAT; i++) begin
        s2[i] <= s2[i-1];
      end
      zl[0] <= (c == '0);
      for (int i = 1; i < ZLEN; i++) begin
        zl[i] <= zl[i-1];
      end
      a3[0] <= s2[qext_pkg::POW_LAT-1].a;
      for (int i = 1; i < qext_pkg::MUL_LAT; i++) begin
        a3[i] <= a3[i-1];
      end
    end
  end

  // Right-to-left square and multiply for c^(p-2), one step per exponent bit.
  assign base[0] = c;
  assign acc[0] = qext_pkg::ONE;

  for (genvar i = 0; i < qext_pkg::POW_STEPS; i++) begin : g_pow
    if (i < qext_pkg::POW_STEPS - 1) begin : g_sq
      qext_mulmod u_sq (.clk(clk), .en(en), .x(base[i]), .y(base[i]), .z(base[i+1]));
    end
    if (qext_pkg::EXP[i]) begin : g_mul
      qext_mulmod u_acc (.clk(clk), .en(en), .x(acc[i]), .y(base[i]), .z(acc[i+1]));
    end else begin : g_hold
      qext_pkg::fe_t dl [qext_pkg::MUL_LAT];
      always_ff @(posedge clk) begin
        if (en) begin
          dl[0] <= acc[i];
          for (int j = 1; j < qext_pkg::MUL_LAT; j++) begin
            dl[j] <= dl[j-1];
          end
        end
      end
      assign acc[i+1] = dl[qext_pkg::MUL_LAT-1];
    end
  end

  qext_mulmod u_m0 (.clk(clk), .en(en), .x(s2[qext_pkg::POW_LAT-1].n0),
                    .y(acc[qext_pkg::POW_STEPS]), .z(m0));
  qext_mulmod u_m2 (.clk(clk), .en(en), .x(s2[qext_pkg::POW_LAT-1].n2),
                    .y(acc[qext_pkg::POW_STEPS]), .z(m2));

  assign aa = a3[qext_pkg::MUL_LAT-1];

  qext_mulmod u_p0 (.clk(clk), .en(en), .x(aa[0]), .y(m0), .z(p_a0m0));
  qext_mulmod u_p1 (.clk(clk), .en(en), .x(aa[2]), .y(m2), .z(p_a2m2));
  qext_mulmod u_p2 (.clk(clk), .en(en), .x(aa[1]), .y(m0), .z(p_a1m0));
  qext_mulmod u_p3 (.clk(clk), .en(en), .x(aa[3]), .y(m2), .z(p_a3m2));
  qext_mulmod u_p4 (.clk(clk), .en(en), .x(aa[2]), .y(m0), .z(p_a2m0));
  qext_mulmod u_p5 (.clk(clk), .en(en), .x(aa[0]), .y(m2), .z(p_a0m2));
  qext_mulmod u_p6 (.clk(clk), .en(en), .x(aa[1]), .y(m2), .z(p_a1m2));
  qext_mulmod u_p7 (.clk(clk), .en(en), .x(aa[3]), .y(m0), .z(p_a3m0));

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= qext_pkg::fadd(p_a0m0, qext_pkg::mul11(p_a2m2));
      r[1] <= qext_pkg::fsub(qext_pkg::fneg(p_a1m0), qext_pkg::mul11(p_a3m2));
      r[2] <= qext_pkg::fsub(p_a2m0, p_a0m2);
      r[3] <= qext_pkg::fsub(p_a1m2, p_a3m0);
      zero <= zl[ZLEN-1];
    end
  end

endmodule
